[rtl/lsb_stego_stream_decoder_assert.svh]
// Assertion macros used by the checker file of the stego stream decoder.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef LSB_STEGO_STREAM_DECODER_ASSERT_SVH
`define LSB_STEGO_STREAM_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lsd_pkg.sv]
// Package of the stego stream decoder: widths, codes, shared types and helpers.
// No dependencies; every other file of the block but the assertion macro header imports it.
`timescale 1ns / 1ps
`default_nettype none

package lsd_pkg;

    localparam int MAX_TAG_CHARS = 8;
    localparam int SIZE_BITS     = 32;
    localparam int CHAR_BITS     = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [1:0] ERR_MAGIC  = 2'd0;
    localparam logic [1:0] ERR_EXTLEN = 2'd1;
    localparam logic [1:0] ERR_EXT    = 2'd2;

    typedef struct packed {
        logic [7:0]  header_skip;
        logic [63:0] magic_chars;
        logic [3:0]  magic_length;
        logic [63:0] ext_chars;
        logic [3:0]  ext_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       error;
        logic [1:0] error_kind;
    } t_result;

    // A length of zero counts as one; anything above the tag limit is clamped.
    function automatic logic [3:0] eff_len(input logic [3:0] len);
        logic [3:0] r;
        if (len == 4'd0) begin
            r = 4'd1;
        end else if (len > 4'(MAX_TAG_CHARS)) begin
            r = 4'(MAX_TAG_CHARS);
        end else begin
            r = len;
        end
        return r;
    endfunction

    function automatic logic [7:0] char_at(input logic [63:0] packed_chars,
                                           input logic [2:0]  idx);
        return packed_chars[{idx, 3'b000} +: CHAR_BITS];
    endfunction

endpackage

`default_nettype wire

[rtl/lsd_if.sv]
// Handshake interfaces of the stego stream decoder: cover input, decoded output
// and register write channel. Depends on lsd_pkg for the channel widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsd_in_if import lsd_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] cover_byte;
    logic       frame_start;

    modport source (output valid, output cover_byte, output frame_start, input ready);
    modport sink   (input valid, input cover_byte, input frame_start, output ready);
endinterface

interface lsd_out_if import lsd_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       error;
    logic [1:0] error_kind;

    modport source (output valid, output data_byte, output last_byte, output error,
                    output error_kind, input ready);
    modport sink   (input valid, input data_byte, input last_byte, input error,
                    input error_kind, output ready);
endinterface

interface lsd_cfg_if import lsd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/lsb_stego_stream_decoder.sv]
// Top level of the LSB stego stream decoder: config registers, frame decoder
// and result buffer. Depends on lsd_pkg, lsd_if, lsd_cfg, lsd_core, lsd_obuf.
//
//   Channel   Direction  Words
//   i_in      in         cover_byte, frame_start
//   o_out     out        data_byte, last_byte, error, error_kind
//   i_cfg     in         index, data (register write)
//
// One cover word is taken in every cycle while i_in.ready is high; its result, if any,
// is registered in the result register, or in the skid register while o_out stalls.
// i_in.ready falls only while two results wait, held in the result and skid
// registers; i_cfg is always ready.
// Synchronous reset restores the register defaults, clears the frame state
// and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module lsb_stego_stream_decoder import lsd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lsd_in_if.sink    i_in,
    lsd_out_if.source o_out,
    lsd_cfg_if.sink   i_cfg
);

    t_cfg    cfg;
    t_result res;
    t_result out_res;
    logic    res_valid;
    logic    can_push;
    logic    in_fire;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = can_push;
    assign in_fire     = i_in.valid && can_push;

    lsd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    lsd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_cover_byte  (i_in.cover_byte),
        .i_frame_start (i_in.frame_start),
        .i_cfg         (cfg),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    lsd_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_fire && res_valid),
        .i_push_res (res),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .o_res      (out_res),
        .i_ready    (o_out.ready)
    );

    assign o_out.data_byte  = out_res.data_byte;
    assign o_out.last_byte  = out_res.last_byte;
    assign o_out.error      = out_res.error;
    assign o_out.error_kind = out_res.error_kind;

endmodule

`default_nettype wire

[rtl/lsd_cfg.sv]
// Configuration register file of the stego stream decoder.
// Depends on lsd_pkg for the register struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module lsd_cfg import lsd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    localparam logic [CFG_IDX_W-1:0] IDX_HEADER_SKIP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_MAGIC_CHARS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_MAGIC_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_EXT_CHARS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_EXT_LENGTH   = 3'd4;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_skip  <= 8'd54;
            r_cfg.magic_chars  <= 64'd0;
            r_cfg.magic_length <= 4'd2;
            r_cfg.ext_chars    <= 64'd0;
            r_cfg.ext_length   <= 4'd4;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                IDX_HEADER_SKIP:  r_cfg.header_skip  <= i_wr_data[7:0];
                IDX_MAGIC_CHARS:  r_cfg.magic_chars  <= i_wr_data;
                IDX_MAGIC_LENGTH: r_cfg.magic_length <= i_wr_data[3:0];
                IDX_EXT_CHARS:    r_cfg.ext_chars    <= i_wr_data;
                IDX_EXT_LENGTH:   r_cfg.ext_length   <= i_wr_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/lsd_core.sv]
// Frame decoder of the stego stream decoder: phase state, bit gathering and
// tag checks for one accepted word per cycle. Depends on lsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsd_core import lsd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_cover_byte,
    input  wire logic       i_frame_start,
    input  wire t_cfg       i_cfg,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_MAGIC   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_EXT     = 3'd3;
    localparam logic [2:0] PH_SIZE    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_HALT    = 3'd7;

    logic [2:0]           r_phase, n_phase;
    logic [7:0]           r_skip,  n_skip;
    logic [4:0]           r_bc,    n_bc;
    logic [7:0]           r_chs,   n_chs;
    logic [SIZE_BITS-1:0] r_cnt,   n_cnt;
    logic [2:0]           r_ci,    n_ci;
    logic [SIZE_BITS-1:0] r_rem,   n_rem;

    logic [2:0]           ph;
    logic [7:0]           skip;
    logic [4:0]           bc;
    logic [7:0]           chs;
    logic [SIZE_BITS-1:0] cnt;
    logic [2:0]           ci;
    logic [SIZE_BITS-1:0] rem;
    logic [7:0]           chs_new;
    logic [SIZE_BITS-1:0] cnt_new;
    logic [SIZE_BITS-1:0] rem_dec;
    logic                 is_magic;
    logic [63:0]          tag_chars;
    logic [3:0]           tag_len;
    logic                 hid_bit;

    always_comb begin
        // A frame start clears every phase register before the word is used.
        ph   = i_frame_start ? PH_HEADER : r_phase;
        skip = i_frame_start ? 8'd0 : r_skip;
        bc   = i_frame_start ? 5'd0 : r_bc;
        chs  = i_frame_start ? 8'd0 : r_chs;
        cnt  = i_frame_start ? '0 : r_cnt;
        ci   = i_frame_start ? 3'd0 : r_ci;
        rem  = i_frame_start ? '0 : r_rem;

        hid_bit = i_cover_byte[0];
        if (ph == PH_HEADER && skip >= i_cfg.header_skip) begin
            ph = PH_MAGIC;
        end

        chs_new           = chs;
        chs_new[bc[2:0]]  = hid_bit;
        cnt_new           = cnt;
        cnt_new[bc]       = hid_bit;
        rem_dec           = rem - SIZE_BITS'(1);
        is_magic          = (ph == PH_MAGIC);
        tag_chars         = is_magic ? i_cfg.magic_chars : i_cfg.ext_chars;
        tag_len           = eff_len(is_magic ? i_cfg.magic_length : i_cfg.ext_length);

        n_phase = ph;
        n_skip  = skip;
        n_bc    = bc;
        n_chs   = chs;
        n_cnt   = cnt;
        n_ci    = ci;
        n_rem   = rem;

        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (ph)
            PH_HEADER: begin
                n_skip = skip + 8'd1;
            end
            PH_EXTLEN, PH_SIZE: begin
                if (bc != 5'(SIZE_BITS - 1)) begin
                    n_bc  = bc + 5'd1;
                    n_cnt = cnt_new;
                end else begin
                    n_bc  = 5'd0;
                    n_cnt = '0;
                    if (ph == PH_EXTLEN) begin
                        if (cnt_new != SIZE_BITS'(eff_len(i_cfg.ext_length))) begin
                            n_phase            = PH_HALT;
                            o_res_valid        = 1'b1;
                            o_res.error        = 1'b1;
                            o_res.error_kind   = ERR_EXTLEN;
                        end else begin
                            n_phase = PH_EXT;
                            n_ci    = 3'd0;
                        end
                    end else begin
                        n_rem   = cnt_new;
                        n_phase = (cnt_new == '0) ? PH_DONE : PH_PAYLOAD;
                    end
                end
            end
            PH_MAGIC, PH_EXT, PH_PAYLOAD: begin
                if (bc[2:0] != 3'd7) begin
                    n_bc  = bc + 5'd1;
                    n_chs = chs_new;
                end else begin
                    n_bc  = 5'd0;
                    n_chs = 8'd0;
                    if (ph == PH_PAYLOAD) begin
                        n_rem           = rem_dec;
                        o_res_valid     = 1'b1;
                        o_res.data_byte = chs_new;
                        if (rem_dec == '0) begin
                            n_phase         = PH_DONE;
                            o_res.last_byte = 1'b1;
                        end
                    end else if (chs_new != char_at(tag_chars, ci)) begin
                        n_phase          = PH_HALT;
                        o_res_valid      = 1'b1;
                        o_res.error      = 1'b1;
                        o_res.error_kind = is_magic ? ERR_MAGIC : ERR_EXT;
                    end else if ({1'b0, ci} + 4'd1 >= tag_len) begin
                        n_ci    = 3'd0;
                        n_phase = is_magic ? PH_EXTLEN : PH_SIZE;
                    end else begin
                        n_ci = ci + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_skip  <= 8'd0;
            r_bc    <= 5'd0;
            r_chs   <= 8'd0;
            r_cnt   <= '0;
            r_ci    <= 3'd0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_bc    <= n_bc;
            r_chs   <= n_chs;
            r_cnt   <= n_cnt;
            r_ci    <= n_ci;
            r_rem   <= n_rem;
        end
    end

endmodule

`default_nettype wire

[rtl/lsd_obuf.sv]
// Result register with a skid stage for the stego stream decoder output.
// Depends on lsd_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module lsd_obuf import lsd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_res,
    output logic         o_can_push,
    output logic         o_valid,
    output t_result      o_res,
    input  wire logic    i_ready
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
                n_out       = i_push_res;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

endmodule

`default_nettype wire

[rtl/lsd_checker.sv]
// Port-level checker of the stego stream decoder and its bind to the top level.
// Depends on lsd_pkg and the macros in lsb_stego_stream_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lsb_stego_stream_decoder_assert.svh"

module lsd_checker import lsd_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_data_byte,
    input wire logic       i_last_byte,
    input wire logic       i_error,
    input wire logic [1:0] i_error_kind
);

    `LSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_data_byte) && $stable(i_last_byte) && $stable(i_error) && $stable(i_error_kind), "stalled output word changed")
    `LSD_ASSERT_SAME(a_err_clean, i_clk, i_rst_n, i_out_valid && i_error, i_data_byte == 8'd0 && !i_last_byte, "error word carries payload bits")
    `LSD_ASSERT_SAME(a_data_kind, i_clk, i_rst_n, i_out_valid && !i_error, i_error_kind == ERR_MAGIC, "payload word carries an error kind")
    `LSD_ASSERT_SAME(a_err_kind, i_clk, i_rst_n, i_out_valid && i_error, i_error_kind == ERR_MAGIC || i_error_kind == ERR_EXTLEN || i_error_kind == ERR_EXT, "unknown error kind")

endmodule

bind lsb_stego_stream_decoder lsd_checker u_lsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_byte  (o_out.data_byte),
    .i_last_byte  (o_out.last_byte),
    .i_error      (o_out.error),
    .i_error_kind (o_out.error_kind)
);

`default_nettype wire
